// File: sv/bdq_pkg.sv
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared types, codes and ring-pointer helpers for the bounded deque unit.
// ----------------------------------------------------------------------------
package bdq_pkg;

  // store geometry
  localparam int DEPTH  = 64;
  localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FILL_W = 7;
  localparam int DATA_W = 32;

  typedef logic [PTR_W-1:0]  ptr_t;
  typedef logic [FILL_W-1:0] fill_t;

  localparam fill_t DEPTH_CNT = FILL_W'(DEPTH);

  // request codes
  localparam logic [2:0] REQ_PUSH_BACK  = 3'd0;
  localparam logic [2:0] REQ_PUSH_FRONT = 3'd1;
  localparam logic [2:0] REQ_POP_FRONT  = 3'd2;
  localparam logic [2:0] REQ_DUMP       = 3'd3;
  localparam logic [2:0] REQ_CLEAR      = 3'd4;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // request beat
  typedef struct packed {
    logic [2:0]               req_type;
    logic signed [DATA_W-1:0] entry_value;
  } req_t;

  // result beat
  typedef struct packed {
    logic signed [DATA_W-1:0] out_value;
    logic                     value_present;
    logic                     last_of_run;
    logic [1:0]               op_status;
    fill_t                    fill_count;
  } rsp_t;

  // memory port command
  typedef struct packed {
    logic              we;
    ptr_t              waddr;
    logic [DATA_W-1:0] wdata;
    logic              re;
    ptr_t              raddr;
  } ram_cmd_t;

  typedef enum logic {
    CTRL_IDLE,
    CTRL_DUMP
  } ctrl_state_t;

  // modular add of two ring positions, both below DEPTH
  function automatic ptr_t ring_add(ptr_t a, ptr_t b);
    logic [PTR_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (PTR_W+1)'(DEPTH)) begin
      s = s - (PTR_W+1)'(DEPTH);
    end
    return s[PTR_W-1:0];
  endfunction

  function automatic ptr_t ring_inc(ptr_t a);
    return ring_add(a, ptr_t'(1));
  endfunction

  function automatic ptr_t ring_dec(ptr_t a);
    ptr_t r;
    if (a == '0) begin
      r = ptr_t'(DEPTH - 1);
    end else begin
      r = a - ptr_t'(1);
    end
    return r;
  endfunction

endpackage

// File: sv/bdq_ram.sv
// ----------------------------------------------------------------------------
// bdq_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module bdq_ram #(
  parameter int DATA_W  = 32,
  parameter int ENTRIES = 64,
  parameter int ADDR_W  = 6
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [ENTRIES];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, data holds between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: sv/bdq_ctrl.sv
// ----------------------------------------------------------------------------
// bdq_ctrl
// Head/count bookkeeping, memory command generation and dump sequencing.
// ----------------------------------------------------------------------------
module bdq_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      req_valid,
  output logic                      req_ready,
  input  bdq_pkg::req_t             req,
  input  logic                      out_free,
  output logic                      load,
  output bdq_pkg::rsp_t             beat,
  output bdq_pkg::ram_cmd_t         ram,
  input  logic [bdq_pkg::DATA_W-1:0] rdata
);

  bdq_pkg::ctrl_state_t state, state_next;
  bdq_pkg::ptr_t        head, head_next;
  bdq_pkg::fill_t       count, count_next;
  bdq_pkg::ptr_t        rd_ptr, rd_ptr_next;
  bdq_pkg::fill_t       issued, issued_next;
  logic                 pending, pending_next;
  logic                 pend_last, pend_last_next;

  logic       accept;
  logic       load_dump;
  logic       issue;
  logic [1:0] status;
  logic       dump_run;

  // handshake and dump flow terms
  always_comb begin
    req_ready = (state == bdq_pkg::CTRL_IDLE) && out_free;
    accept    = req_valid && req_ready;
    load_dump = (state == bdq_pkg::CTRL_DUMP) && pending && out_free;
    issue     = (state == bdq_pkg::CTRL_DUMP) && (issued != count) &&
                (!pending || load_dump);
    dump_run  = (req.req_type == bdq_pkg::REQ_DUMP) && (count != '0);
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      bdq_pkg::CTRL_IDLE: begin
        if (accept && dump_run) begin
          state_next = bdq_pkg::CTRL_DUMP;
        end
      end
      bdq_pkg::CTRL_DUMP: begin
        if (load_dump && pend_last) begin
          state_next = bdq_pkg::CTRL_IDLE;
        end
      end
      default: state_next = bdq_pkg::CTRL_IDLE;
    endcase
  end

  // outputs and datapath next values
  always_comb begin
    head_next      = head;
    count_next     = count;
    rd_ptr_next    = rd_ptr;
    issued_next    = issued;
    pending_next   = pending;
    pend_last_next = pend_last;
    status         = bdq_pkg::ST_OK;
    ram            = '0;
    ram.wdata      = req.entry_value;
    ram.raddr      = rd_ptr;

    // request decode
    if (accept) begin
      case (req.req_type)
        bdq_pkg::REQ_PUSH_BACK: begin
          if (count >= bdq_pkg::DEPTH_CNT) begin
            status = bdq_pkg::ST_FULL;
          end else begin
            ram.we     = 1'b1;
            ram.waddr  = bdq_pkg::ring_add(head, count[bdq_pkg::PTR_W-1:0]);
            count_next = count + 1'b1;
          end
        end
        bdq_pkg::REQ_PUSH_FRONT: begin
          if (count >= bdq_pkg::DEPTH_CNT) begin
            status = bdq_pkg::ST_FULL;
          end else begin
            head_next  = bdq_pkg::ring_dec(head);
            ram.we     = 1'b1;
            ram.waddr  = head_next;
            count_next = count + 1'b1;
          end
        end
        bdq_pkg::REQ_POP_FRONT: begin
          if (count == '0) begin
            status = bdq_pkg::ST_EMPTY;
          end else begin
            head_next  = bdq_pkg::ring_inc(head);
            count_next = count - 1'b1;
          end
        end
        bdq_pkg::REQ_DUMP: begin
          rd_ptr_next = head;
          issued_next = '0;
        end
        bdq_pkg::REQ_CLEAR: begin
          head_next  = '0;
          count_next = '0;
        end
        default: ;
      endcase
    end

    // dump read issue, one entry a cycle while the result side keeps up
    if (issue) begin
      ram.re         = 1'b1;
      rd_ptr_next    = bdq_pkg::ring_inc(rd_ptr);
      issued_next    = issued + 1'b1;
      pending_next   = 1'b1;
      pend_last_next = ((issued + 1'b1) == count);
    end else if (load_dump) begin
      pending_next = 1'b0;
    end

    // result beat
    if (state == bdq_pkg::CTRL_DUMP) begin
      load               = load_dump;
      beat.out_value     = rdata;
      beat.value_present = 1'b1;
      beat.last_of_run   = pend_last;
      beat.op_status     = bdq_pkg::ST_OK;
      beat.fill_count    = count;
    end else begin
      load               = accept && !dump_run;
      beat.out_value     = '0;
      beat.value_present = 1'b0;
      beat.last_of_run   = 1'b1;
      beat.op_status     = status;
      beat.fill_count    = count_next;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= bdq_pkg::CTRL_IDLE;
      head      <= '0;
      count     <= '0;
      issued    <= '0;
      pending   <= 1'b0;
      pend_last <= 1'b0;
    end else begin
      state     <= state_next;
      head      <= head_next;
      count     <= count_next;
      issued    <= issued_next;
      pending   <= pending_next;
      pend_last <= pend_last_next;
    end
  end

  always_ff @(posedge clk) begin
    rd_ptr <= rd_ptr_next;
  end

  // fill level never passes the store size
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= bdq_pkg::DEPTH_CNT)
    else $error("fill count exceeds depth");

  // no store writes while a dump is reading
  a_no_write_in_dump: assert property (@(posedge clk) disable iff (rst)
    (state == bdq_pkg::CTRL_DUMP) |-> !ram.we)
    else $error("write during dump");

  // read data waits only inside a dump
  a_pending_in_dump: assert property (@(posedge clk) disable iff (rst)
    pending |-> (state == bdq_pkg::CTRL_DUMP))
    else $error("pending read outside dump");

  // reads issued never pass the fill count
  a_issue_bound: assert property (@(posedge clk) disable iff (rst)
    (state == bdq_pkg::CTRL_DUMP) |-> (issued <= count))
    else $error("dump overran fill count");

  // handing over the last entry ends the dump
  a_dump_end: assert property (@(posedge clk) disable iff (rst)
    (load_dump && pend_last) |=> (state == bdq_pkg::CTRL_IDLE))
    else $error("dump did not end after last beat");

endmodule

// File: sv/bounded_deque_with_dump_unit.sv
// ----------------------------------------------------------------------------
// bounded_deque_with_dump_unit
// Bounded double-ended queue of signed 32-bit entries with a dump request.
// ----------------------------------------------------------------------------
// Entries live in a 64-entry ring held in one simple dual-port RAM. Push back,
// push front, pop front, clear and unused request codes each return one
// result beat; a new request is taken every cycle as long as the result side
// keeps up. A dump of N stored entries returns N beats and holds off new
// requests until the last one is handed over: the single RAM read port yields
// one entry per cycle, stalling with the result side, and each read passes the
// RAM read register and then the result register. An empty dump returns one
// beat. The store needs no clearing after reset; only written entries are read.
module bounded_deque_with_dump_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  bdq_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output bdq_pkg::rsp_t rsp
);

  logic                       out_free;
  logic                       load;
  bdq_pkg::rsp_t              beat;
  bdq_pkg::ram_cmd_t          ram;
  logic [bdq_pkg::DATA_W-1:0] rdata;

  assign out_free = !rsp_valid || rsp_ready;

  // control and bookkeeping
  bdq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .out_free  (out_free),
    .load      (load),
    .beat      (beat),
    .ram       (ram),
    .rdata     (rdata)
  );

  // entry store
  bdq_ram #(
    .DATA_W  (bdq_pkg::DATA_W),
    .ENTRIES (bdq_pkg::DEPTH),
    .ADDR_W  (bdq_pkg::PTR_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram.we),
    .waddr (ram.waddr),
    .wdata (ram.wdata),
    .re    (ram.re),
    .raddr (ram.raddr),
    .rdata (rdata)
  );

  // result output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rsp <= beat;
    end
  end

endmodule

// File: dv/bounded_deque_with_dump_unit_tb.sv
// ----------------------------------------------------------------------------
// bounded_deque_with_dump_unit_tb
// Self-checking bench for the bounded deque with dump.
// A directed table covers the empty, head-wrap and spare-code corners. Random
// phases then fill, drain and mix requests. Each accepted request goes through
// a shadow deque that queues the beats the unit must return. Returned beats
// are compared in order, field by field. Both handshakes idle at random, and
// one long result hold-off backs the unit up into its request port.
// ----------------------------------------------------------------------------
module bounded_deque_with_dump_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // spare request codes, answered with a plain ok beat
  localparam logic [2:0] REQ_SPARE_5 = 3'd5;
  localparam logic [2:0] REQ_SPARE_6 = 3'd6;
  localparam logic [2:0] REQ_SPARE_7 = 3'd7;

  localparam int HOLD_CYCLES  = 200;
  localparam int DRAIN_LIMIT  = 20000;
  localparam int TIMEOUT_NS   = 10_000_000;
  localparam int MAX_REPORTS  = 10;

  // directed stimulus row; typed rows carry their one expected beat
  typedef struct packed {
    logic [2:0]     kind;
    logic [31:0]    value;
    logic           typed;
    logic [1:0]     status;
    bdq_pkg::fill_t fill;
  } dir_row_t;

  localparam int NUM_ROWS = 23;
  localparam dir_row_t DIRECTED_ROWS [NUM_ROWS] = '{
    {bdq_pkg::REQ_POP_FRONT,  32'h0000_0000, 1'b1, bdq_pkg::ST_EMPTY, 7'd0},  // pop on empty
    {bdq_pkg::REQ_DUMP,       32'h0000_0000, 1'b1, bdq_pkg::ST_OK,    7'd0},  // dump on empty
    {REQ_SPARE_5,             32'hFFFF_FFFF, 1'b1, bdq_pkg::ST_OK,    7'd0},
    {bdq_pkg::REQ_PUSH_BACK,  32'h7FFF_FFFF, 1'b1, bdq_pkg::ST_OK,    7'd1},
    {bdq_pkg::REQ_PUSH_FRONT, 32'h8000_0000, 1'b1, bdq_pkg::ST_OK,    7'd2},
    {bdq_pkg::REQ_PUSH_BACK,  32'hFFFF_FFFF, 1'b0, bdq_pkg::ST_OK,    7'd0},
    {bdq_pkg::REQ_PUSH_FRONT, 32'h0000_0000, 1'b0, bdq_pkg::ST_OK,    7'd0},
    {bdq_pkg::REQ_DUMP,       32'h0000_0000, 1'b0, bdq_pkg::ST_OK,    7'd0},
    {bdq_pkg::REQ_POP_FRONT,  32'h1234_5678, 1'b0, bdq_pkg::ST_OK,    7'd0},
    {REQ_SPARE_6,             32'hAAAA_AAAA, 1'b0, bdq_pkg::ST_OK,    7'd0},
    {REQ_SPARE_7,             32'h5555_5555, 1'b0, bdq_pkg::ST_OK,    7'd0},
    {bdq_pkg::REQ_DUMP,       32'hFFFF_FFFF, 1'b0, bdq_pkg::ST_OK,    7'd0},
    {bdq_pkg::REQ_CLEAR,      32'h0000_0000, 1'b1, bdq_pkg::ST_OK,    7'd0},
    {bdq_pkg::REQ_DUMP,       32'h0000_0000, 1'b1, bdq_pkg::ST_OK,    7'd0},  // contents hidden
    {bdq_pkg::REQ_POP_FRONT,  32'h0000_0000, 1'b1, bdq_pkg::ST_EMPTY, 7'd0},
    {bdq_pkg::REQ_PUSH_FRONT, 32'h1234_5678, 1'b1, bdq_pkg::ST_OK,    7'd1},  // head wraps
    {bdq_pkg::REQ_PUSH_FRONT, 32'hFEDC_BA98, 1'b0, bdq_pkg::ST_OK,    7'd0},
    {bdq_pkg::REQ_DUMP,       32'h0000_0000, 1'b0, bdq_pkg::ST_OK,    7'd0},
    {bdq_pkg::REQ_POP_FRONT,  32'h0000_0000, 1'b0, bdq_pkg::ST_OK,    7'd0},
    {bdq_pkg::REQ_POP_FRONT,  32'h0000_0000, 1'b0, bdq_pkg::ST_OK,    7'd0},
    {bdq_pkg::REQ_POP_FRONT,  32'h0000_0000, 1'b0, bdq_pkg::ST_OK,    7'd0},
    {bdq_pkg::REQ_PUSH_BACK,  32'h0000_0001, 1'b0, bdq_pkg::ST_OK,    7'd0},
    {bdq_pkg::REQ_DUMP,       32'h0000_0000, 1'b0, bdq_pkg::ST_OK,    7'd0}
  };

  logic          clk;
  logic          rst;
  logic          req_valid;
  logic          req_ready;
  bdq_pkg::req_t req;
  logic          rsp_valid;
  logic          rsp_ready;
  bdq_pkg::rsp_t rsp;

  // shadow deque state
  logic signed [bdq_pkg::DATA_W-1:0] shadow_store [bdq_pkg::DEPTH];
  bdq_pkg::ptr_t                     shadow_head;
  bdq_pkg::fill_t                    shadow_count;

  bdq_pkg::rsp_t expected_beats [$];
  int            error_count;

  // handshake between the stimulus thread and the checker / receiver
  bit            typed_now;
  bdq_pkg::rsp_t typed_beat;
  bit            send_calm;
  bit            recv_calm;
  bit            hold_pending;

  bounded_deque_with_dump_unit dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  // clock
  initial clk = 1'b0;
  always #2 clk = ~clk;

  // hard stop
  initial begin
    #(TIMEOUT_NS);
    $display("TB_ERROR");
    $finish;
  end

  function automatic string beat_str(bdq_pkg::rsp_t b);
    return $sformatf("value=%0d present=%0b last=%0b status=%0d fill=%0d",
                     b.out_value, b.value_present, b.last_of_run, b.op_status,
                     b.fill_count);
  endfunction

  function automatic void note_error(string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) begin
      $display("%s", msg);
    end
  endfunction

  // append one beat at the tail of the expectation queue
  function automatic void expect_beat(bdq_pkg::rsp_t b);
    expected_beats.insert(expected_beats.size(), b);
  endfunction

  // gap length: mostly none, some short, a few long
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 19);
    if (roll < 12) begin
      return 0;
    end else if (roll < 19) begin
      return $urandom_range(1, 3);
    end else begin
      return $urandom_range(10, 40);
    end
  endfunction

  // shadow deque: apply one request, queue the beats it must produce
  task automatic deque_model_step(input bdq_pkg::req_t r);
    bdq_pkg::rsp_t beat;
    int            slot;
    bit            dumped;
    beat = '0;
    beat.last_of_run = 1'b1;
    beat.op_status = bdq_pkg::ST_OK;
    dumped = 1'b0;
    case (r.req_type)
      bdq_pkg::REQ_PUSH_BACK: begin
        if (shadow_count == bdq_pkg::DEPTH_CNT) begin
          beat.op_status = bdq_pkg::ST_FULL;
        end else begin
          slot = (int'(shadow_head) + int'(shadow_count)) % bdq_pkg::DEPTH;
          shadow_store[slot] = r.entry_value;
          shadow_count = shadow_count + 1'b1;
        end
      end
      bdq_pkg::REQ_PUSH_FRONT: begin
        if (shadow_count == bdq_pkg::DEPTH_CNT) begin
          beat.op_status = bdq_pkg::ST_FULL;
        end else begin
          shadow_head = bdq_pkg::ptr_t'((int'(shadow_head) + bdq_pkg::DEPTH - 1) %
                                        bdq_pkg::DEPTH);
          shadow_store[shadow_head] = r.entry_value;
          shadow_count = shadow_count + 1'b1;
        end
      end
      bdq_pkg::REQ_POP_FRONT: begin
        if (shadow_count == '0) begin
          beat.op_status = bdq_pkg::ST_EMPTY;
        end else begin
          shadow_head = bdq_pkg::ptr_t'((int'(shadow_head) + 1) % bdq_pkg::DEPTH);
          shadow_count = shadow_count - 1'b1;
        end
      end
      bdq_pkg::REQ_DUMP: begin
        // one beat per entry, front to back, last one marked
        for (int i = 0; i < int'(shadow_count); i++) begin
          slot = (int'(shadow_head) + i) % bdq_pkg::DEPTH;
          beat.out_value = shadow_store[slot];
          beat.value_present = 1'b1;
          beat.last_of_run = (i == int'(shadow_count) - 1);
          beat.fill_count = shadow_count;
          expect_beat(beat);
          dumped = 1'b1;
        end
      end
      bdq_pkg::REQ_CLEAR: begin
        shadow_head = '0;
        shadow_count = '0;
      end
      default: begin
      end
    endcase
    if (!dumped) begin
      beat.fill_count = shadow_count;
      expect_beat(beat);
    end
  endtask

  task automatic check_beat(input bdq_pkg::rsp_t got);
    bdq_pkg::rsp_t want;
    if (expected_beats.size() == 0) begin
      note_error({"unexpected beat: ", beat_str(got)});
    end else begin
      want = expected_beats.pop_front();
      if (got.out_value !== want.out_value || got.value_present !== want.value_present ||
          got.last_of_run !== want.last_of_run || got.op_status !== want.op_status ||
          got.fill_count !== want.fill_count) begin
        note_error({"beat mismatch: expected ", beat_str(want), " got ", beat_str(got)});
      end
    end
  endtask

  // both handshakes seen at the rising edge; request first so the
  // expectation exists before any beat it causes is checked
  always @(posedge clk) begin
    int mark;
    if (!rst) begin
      if (req_valid && req_ready) begin
        mark = expected_beats.size();
        deque_model_step(req);
        if (typed_now) begin
          while (expected_beats.size() > mark) begin
            void'(expected_beats.pop_back());
          end
          expect_beat(typed_beat);
        end
      end
      if (rsp_valid && rsp_ready) begin
        check_beat(rsp);
      end
    end
  end

  // result side: random stalls, one long hold-off on request
  initial begin : receiver
    int idle_left;
    idle_left = 0;
    rsp_ready = 1'b0;
    wait (!rst);
    forever begin
      @(negedge clk);
      if (hold_pending) begin
        hold_pending = 1'b0;
        rsp_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else if (idle_left > 0) begin
        rsp_ready <= 1'b0;
        idle_left--;
      end else begin
        rsp_ready <= 1'b1;
        idle_left = recv_calm ? 0 : pick_gap();
      end
    end
  end

  // offer one request beat; starts and ends on a falling edge
  task automatic offer(input logic [2:0] kind, input logic [31:0] value,
                       input bit typed, input bdq_pkg::rsp_t want);
    int            gap;
    bdq_pkg::req_t beat;
    gap = send_calm ? 0 : pick_gap();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    beat.req_type = kind;
    beat.entry_value = value;
    req <= beat;
    req_valid <= 1'b1;
    typed_now = typed;
    typed_beat = want;
    do @(posedge clk); while (!req_ready);
    @(negedge clk);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'hFFFF_FFFF;
      3: return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  // random request of any kind, pushes favored
  task automatic offer_mixed();
    int          roll;
    logic [2:0]  kind;
    roll = $urandom_range(0, 99);
    if (roll < 30) begin
      kind = bdq_pkg::REQ_PUSH_BACK;
    end else if (roll < 60) begin
      kind = bdq_pkg::REQ_PUSH_FRONT;
    end else if (roll < 80) begin
      kind = bdq_pkg::REQ_POP_FRONT;
    end else if (roll < 90) begin
      kind = bdq_pkg::REQ_DUMP;
    end else if (roll < 93) begin
      kind = bdq_pkg::REQ_CLEAR;
    end else begin
      kind = 3'($urandom_range(REQ_SPARE_5, REQ_SPARE_7));
    end
    offer(kind, pick_value(), 1'b0, '0);
  endtask

  // main sequence
  initial begin
    bdq_pkg::rsp_t want;
    int            waited;
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    shadow_head = '0;
    shadow_count = '0;
    error_count = 0;
    typed_now = 1'b0;
    typed_beat = '0;
    send_calm = 1'b0;
    recv_calm = 1'b0;
    hold_pending = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed table
    foreach (DIRECTED_ROWS[i]) begin
      want = '0;
      want.last_of_run = 1'b1;
      want.op_status = DIRECTED_ROWS[i].status;
      want.fill_count = DIRECTED_ROWS[i].fill;
      offer(DIRECTED_ROWS[i].kind, DIRECTED_ROWS[i].value, DIRECTED_ROWS[i].typed, want);
    end

    // mixed traffic with idling on both sides
    repeat (30) offer_mixed();

    // fill past full while the result side holds off
    send_calm = 1'b1;
    hold_pending = 1'b1;
    repeat (68) begin
      offer($urandom_range(0, 1) ? bdq_pkg::REQ_PUSH_FRONT : bdq_pkg::REQ_PUSH_BACK,
            pick_value(), 1'b0, '0);
    end
    offer(bdq_pkg::REQ_DUMP, pick_value(), 1'b0, '0);
    send_calm = 1'b0;

    // drain past empty, a few dumps along the way
    repeat (68) begin
      offer(($urandom_range(0, 9) == 0) ? bdq_pkg::REQ_DUMP : bdq_pkg::REQ_POP_FRONT,
            pick_value(), 1'b0, '0);
    end

    // back to back with no idling
    send_calm = 1'b1;
    recv_calm = 1'b1;
    repeat (20) offer_mixed();
    send_calm = 1'b0;
    recv_calm = 1'b0;
    repeat (20) offer_mixed();

    // drain the result side
    req_valid <= 1'b0;
    recv_calm = 1'b1;
    waited = 0;
    while (expected_beats.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (bdq_pkg::DEPTH + 8) @(posedge clk);
    if (expected_beats.size() != 0) begin
      note_error($sformatf("%0d expected beats never arrived", expected_beats.size()));
    end

    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
